// File: hdl/qcr_pkg.sv
// Package for the tag queue with cut-in and keyed removal.
// Holds sizes, request and response structs, and operation and status codes.
// No dependencies.
package qcr_pkg;

  localparam int DEPTH     = 16;
  localparam int TAG_WIDTH = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);

  // Field widths fixed by the interface
  localparam int FUNC_W   = 2;
  localparam int FTAG_W   = 16;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 2'd0,
    FN_INSERT = 2'd1,
    FN_SERVE  = 2'd2,
    FN_REMOVE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [FTAG_W-1:0]  entry_tag;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [FTAG_W-1:0]  served_tag;
    logic               served_valid;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

endpackage

// File: hdl/qcr_slots.sv
// Slot array and fill count of the tag queue, with the per-slot shift logic.
// Decodes one request, updates the slots on fire and returns its response.
// Depends on qcr_pkg.
module qcr_slots (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  qcr_pkg::req_t req,
  output qcr_pkg::rsp_t rsp
);
  import qcr_pkg::*;

  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  logic [TAG_WIDTH-1:0] slots [DEPTH];
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  logic [TAG_WIDTH-1:0] tag;
  logic [DEPTH-1:0]     match;
  logic [DEPTH-1:0]     past;
  logic                 full;
  logic                 empty;
  logic                 found;
  logic                 pos_bad;
  logic [IDX_W-1:0]     ins_idx;
  logic                 do_put;
  logic                 do_serve;
  logic                 do_remove;

  assign tag = TAG_WIDTH'(req.entry_tag);

  // Compare every live slot with the key and mark slots at or after the first hit
  for (genvar i = 0; i < DEPTH; i++) begin : g_match
    localparam logic [DEPTH-1:0] LOW = {DEPTH{1'b1}} >> (DEPTH - 1 - i);
    assign match[i] = (slots[i] == tag) && (CNT_W'(i) < count);
    assign past[i]  = |(match & LOW);
  end

  assign found = |match;
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign pos_bad = (req.position == '0) ||
                   (CMP_W'(req.position) > (CMP_W'(count) + CMP_W'(1)));

  // Decode the request and build the response
  always_comb begin
    do_put       = 1'b0;
    do_serve     = 1'b0;
    do_remove    = 1'b0;
    ins_idx      = IDX_W'(count);
    rsp.status       = ST_OK;
    rsp.served_tag   = '0;
    rsp.served_valid = 1'b0;
    unique case (req.func)
      FN_APPEND: begin
        if (full) rsp.status = ST_FULL;
        else do_put = 1'b1;
      end
      FN_INSERT: begin
        ins_idx = IDX_W'(req.position - POS_W'(1));
        if (full) rsp.status = ST_FULL;
        else if (pos_bad) rsp.status = ST_BADPOS;
        else do_put = 1'b1;
      end
      FN_SERVE: begin
        if (empty) begin
          rsp.status = ST_EMPTY;
        end else begin
          do_serve         = 1'b1;
          rsp.served_tag   = FTAG_W'(slots[0]);
          rsp.served_valid = 1'b1;
        end
      end
      FN_REMOVE: begin
        if (empty) begin
          rsp.status = ST_EMPTY;
        end else if (!found) begin
          rsp.status = ST_NOTFOUND;
        end else begin
          do_remove        = 1'b1;
          rsp.served_tag   = FTAG_W'(tag);
          rsp.served_valid = 1'b1;
        end
      end
      default: rsp.status = ST_OK;
    endcase
    if (do_put) count_next = count + CNT_W'(1);
    else if (do_serve || do_remove) count_next = count - CNT_W'(1);
    else count_next = count;
    rsp.occupancy = OCC_W'(count_next);
  end

  // Shift each slot: open a hole on insert, close the gap on serve or removal
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic take;
    assign take = do_serve || (do_remove && past[i]);
    always_ff @(posedge clk) begin
      if (fire) begin
        if (do_put) begin
          if (IDX_W'(i) == ins_idx) begin
            slots[i] <= tag;
          end else if (IDX_W'(i) > ins_idx) begin
            if (i > 0) slots[i] <= slots[(i > 0) ? i - 1 : 0];
          end
        end else if (take) begin
          if (i < DEPTH - 1) slots[i] <= slots[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Hold the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

endmodule

// File: hdl/queue_with_cut_in_and_keyed_removal.sv
// Tag queue with append, positional insert, head serve and keyed removal.
// A transaction held in the input register moves its response to the output register
// when it fires, which a stalled output holds back. Throughput: one transaction per
// cycle unless the output stalls, set by the slot compare and shift between the two.
// Reset (rst, synchronous) empties the queue and both registers.
// Depends on qcr_pkg and qcr_slots.
module queue_with_cut_in_and_keyed_removal (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  qcr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output qcr_pkg::rsp_t rsp
);
  import qcr_pkg::*;

  logic  req_held_vld;
  req_t  req_held;
  logic  out_free;
  logic  fire;
  rsp_t  rsp_comb;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign fire      = req_held_vld && out_free;
  assign req_stall = req_held_vld && !fire;

  // Input register: take a transaction when empty or whenever the held one moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      req_held_vld <= 1'b0;
    end else if (req_valid && !req_stall) begin
      req_held_vld <= 1'b1;
    end else if (fire) begin
      req_held_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) req_held <= req;
  end

  qcr_slots u_slots (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req_held),
    .rsp  (rsp_comb)
  );

  // Output register: hold the response until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) rsp <= rsp_comb;
  end

endmodule
